[hw/rtl/mlf_pkg.sv]
// Shared types and constants for the mail line folder.
// No dependencies; used by mlf_ctrl, mlf_datapath and mail_line_folder.
package mlf_pkg;

    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd60;
    localparam logic [LEN_W-1:0] LEN_MIN   = 6'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_CLR,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_HEAD,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_DOT,
        ST_CONSUME
    } state_t;

    // How the current line is cut
    typedef enum logic [2:0] {
        SEL_CRLF,
        SEL_CAP_BLANK,
        SEL_FOLD,
        SEL_HARD,
        SEL_FLUSH
    } line_sel_t;

    // Kind of word loaded into the output register
    typedef enum logic [2:0] {
        OUT_EMPTY,
        OUT_SPACE,
        OUT_DATA,
        OUT_DOT_FIRST,
        OUT_DOT_LAST
    } out_kind_t;

    typedef struct packed {
        logic      accept;
        logic      scan_clr;
        logic      scan_run;
        logic      line_load;
        line_sel_t line_sel;
        logic      e_inc;
        logic      out_load;
        out_kind_t out_kind;
        logic      consume;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic over;
        logic cap_blank;
        logic fold_ok;
        logic final_text;
        logic fill_zero;
        logic n_zero;
        logic pend;
        logic e_last;
        logic dot;
        logic out_free;
    } sts_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

[hw/rtl/mlf_ctrl.sv]
// Controller state machine of the mail line folder.
// Depends on mlf_pkg; drives mlf_datapath through cmd_t, reads sts_t.
module mlf_ctrl
    import mlf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.line_sel = SEL_CRLF;
        cmd.out_kind = OUT_DATA;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN_CLR;
                end
            end
            ST_SCAN_CLR: begin
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // Pick how the window is cut, or stop for the next word
                state_next    = ST_EMIT_HEAD;
                cmd.line_load = 1'b1;
                priority if (sts.found) begin
                    cmd.line_sel = SEL_CRLF;
                end else if (sts.over && sts.cap_blank) begin
                    cmd.line_sel = SEL_CAP_BLANK;
                end else if (sts.over && sts.fold_ok) begin
                    cmd.line_sel = SEL_FOLD;
                end else if (sts.over) begin
                    cmd.line_sel = SEL_HARD;
                end else if (sts.final_text && !sts.fill_zero) begin
                    cmd.line_sel = SEL_FLUSH;
                end else begin
                    cmd.line_load = 1'b0;
                    cmd.finish    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_HEAD: begin
                if (sts.out_free) begin
                    priority if (sts.n_zero && !sts.pend) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = OUT_EMPTY;
                        state_next   = ST_CONSUME;
                    end else if (sts.pend) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = OUT_SPACE;
                        state_next   = sts.n_zero ? ST_CONSUME : ST_EMIT_RD;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.dot) begin
                        cmd.out_kind = OUT_DOT_FIRST;
                        state_next   = ST_EMIT_DOT;
                    end else begin
                        cmd.out_kind = OUT_DATA;
                        cmd.e_inc    = 1'b1;
                        state_next   = sts.e_last ? ST_CONSUME : ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_DOT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_DOT_LAST;
                    state_next   = ST_CONSUME;
                end
            end
            ST_CONSUME: begin
                cmd.consume = 1'b1;
                state_next  = ST_SCAN_CLR;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mlf_datapath.sv]
// Datapath of the mail line folder: window memory, scan, line cut and output register.
// Depends on mlf_pkg; commanded by mlf_ctrl.
module mlf_datapath
    import mlf_pkg::*;
#(
    parameter int LINE_CAPACITY = 60
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [7:0]       s_in_byte,
    input  logic             s_last_byte,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [7:0]       m_out_byte,
    output logic             m_has_byte,
    output logic             m_end_of_line
);

    localparam int DEPTH = LINE_CAPACITY + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(LINE_CAPACITY + 2);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(LINE_CAPACITY);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    // Circular window store
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             pend_reg;
    logic             final_reg;
    logic [LEN_W-1:0] len_reg;

    logic [CNT_W-1:0] idx_reg;
    logic             chk_v_reg;
    logic [CNT_W-1:0] chk_idx_reg;
    logic [7:0]       prev_reg;
    logic             found_reg;
    logic [CNT_W-1:0] fi_reg;
    logic             blank_seen_reg;
    logic [CNT_W-1:0] blank_j_reg;
    logic             cap_blank_reg;

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic             pend_after_reg;
    logic [CNT_W-1:0] e_reg;

    logic             m_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             has_byte_reg;
    logic             eol_reg;

    logic [LEN_W-1:0] act_len;
    logic [CNT_W-1:0] cap;
    logic             can_issue;
    logic             issue;
    logic [CNT_W-1:0] rd_off;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             out_free;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= DEPTH_S) s = s - DEPTH_S;
        return s[IDX_W-1:0];
    endfunction

    // Effective line length and room left after an owed space
    always_comb begin
        if (len_reg < LEN_MIN) begin
            act_len = LEN_MIN;
        end else if (len_reg > CAP_L) begin
            act_len = CAP_L;
        end else begin
            act_len = len_reg;
        end
        cap = CNT_W'(act_len) - CNT_W'(pend_reg);
    end

    assign can_issue = (idx_reg < fill_reg) && (idx_reg <= cap);
    assign issue     = cmd.scan_run && can_issue;
    assign rd_off    = cmd.scan_run ? idx_reg : e_reg;
    assign rd_addr   = wrap_add(head_reg, rd_off);
    assign wr_addr   = wrap_add(head_reg, fill_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Memory write on accept, registered read every cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept && (fill_reg < CNT_W'(DEPTH))) begin
            mem[wr_addr] <= s_in_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Window bookkeeping and line length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
            final_reg <= 1'b0;
            len_reg   <= LEN_RESET;
        end else begin
            if (cfg_wr_en && (fill_reg == '0)) len_reg <= cfg_wr_data;
            if (cmd.accept) begin
                final_reg <= s_last_byte;
                if (fill_reg < CNT_W'(DEPTH)) fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.consume) begin
                head_reg <= wrap_add(head_reg, k_reg);
                fill_reg <= fill_reg - k_reg;
                pend_reg <= pend_after_reg;
            end
            if (cmd.finish && final_reg) pend_reg <= 1'b0;
        end
    end

    // Serial scan for CR LF, last blank and the blank just past the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            chk_v_reg      <= 1'b0;
            found_reg      <= 1'b0;
            blank_seen_reg <= 1'b0;
            cap_blank_reg  <= 1'b0;
        end else if (cmd.scan_clr) begin
            idx_reg        <= '0;
            chk_v_reg      <= 1'b0;
            found_reg      <= 1'b0;
            blank_seen_reg <= 1'b0;
            cap_blank_reg  <= 1'b0;
        end else if (cmd.scan_run) begin
            chk_v_reg <= issue;
            if (issue) idx_reg <= idx_reg + 1'b1;
            if (chk_v_reg) begin
                if (!found_reg && (chk_idx_reg != '0) && (chk_idx_reg < cap) &&
                    (prev_reg == CHAR_CR) && (rdata_reg == CHAR_LF)) begin
                    found_reg <= 1'b1;
                end
                if ((chk_idx_reg < cap) && is_blank(rdata_reg)) blank_seen_reg <= 1'b1;
                if (chk_idx_reg == cap) cap_blank_reg <= is_blank(rdata_reg);
            end
        end
    end

    // Scan payload
    always_ff @(posedge aclk) begin
        if (cmd.scan_run) begin
            chk_idx_reg <= idx_reg;
            if (chk_v_reg) begin
                prev_reg <= rdata_reg;
                if (!found_reg && (chk_idx_reg != '0) && (chk_idx_reg < cap) &&
                    (prev_reg == CHAR_CR) && (rdata_reg == CHAR_LF)) begin
                    fi_reg <= chk_idx_reg - 1'b1;
                end
                if ((chk_idx_reg < cap) && is_blank(rdata_reg)) blank_j_reg <= chk_idx_reg;
            end
        end
    end

    // Line cut: length, bytes consumed, owed space afterward
    always_ff @(posedge aclk) begin
        if (cmd.line_load) begin
            e_reg <= '0;
            unique case (cmd.line_sel)
                SEL_CRLF: begin
                    n_reg          <= fi_reg;
                    k_reg          <= fi_reg + CNT_W'(2);
                    pend_after_reg <= 1'b0;
                end
                SEL_CAP_BLANK: begin
                    n_reg          <= cap;
                    k_reg          <= cap;
                    pend_after_reg <= 1'b0;
                end
                SEL_FOLD: begin
                    n_reg          <= blank_j_reg;
                    k_reg          <= blank_j_reg;
                    pend_after_reg <= 1'b0;
                end
                SEL_HARD: begin
                    n_reg          <= cap;
                    k_reg          <= cap;
                    pend_after_reg <= 1'b1;
                end
                SEL_FLUSH: begin
                    n_reg          <= fill_reg;
                    k_reg          <= fill_reg;
                    pend_after_reg <= 1'b0;
                end
                default: begin
                    n_reg          <= fill_reg;
                    k_reg          <= fill_reg;
                    pend_after_reg <= 1'b0;
                end
            endcase
        end else if (cmd.e_inc) begin
            e_reg <= e_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (cmd.out_kind)
                OUT_EMPTY: begin
                    out_byte_reg <= 8'h00;
                    has_byte_reg <= 1'b0;
                    eol_reg      <= 1'b1;
                end
                OUT_SPACE: begin
                    out_byte_reg <= CHAR_SPACE;
                    has_byte_reg <= 1'b1;
                    eol_reg      <= (n_reg == '0);
                end
                OUT_DATA: begin
                    out_byte_reg <= rdata_reg;
                    has_byte_reg <= 1'b1;
                    eol_reg      <= sts.e_last;
                end
                OUT_DOT_FIRST: begin
                    out_byte_reg <= CHAR_DOT;
                    has_byte_reg <= 1'b1;
                    eol_reg      <= 1'b0;
                end
                OUT_DOT_LAST: begin
                    out_byte_reg <= CHAR_DOT;
                    has_byte_reg <= 1'b1;
                    eol_reg      <= 1'b1;
                end
                default: begin
                    out_byte_reg <= rdata_reg;
                    has_byte_reg <= 1'b1;
                    eol_reg      <= 1'b1;
                end
            endcase
        end
    end

    // Status to controller
    always_comb begin
        sts.scan_done  = !can_issue && !chk_v_reg;
        sts.found      = found_reg;
        sts.over       = fill_reg > cap;
        sts.cap_blank  = cap_blank_reg;
        sts.fold_ok    = blank_seen_reg && ((blank_j_reg != '0) || pend_reg);
        sts.final_text = final_reg;
        sts.fill_zero  = (fill_reg == '0);
        sts.n_zero     = (n_reg == '0);
        sts.pend       = pend_reg;
        sts.e_last     = (e_reg == (n_reg - 1'b1));
        sts.dot        = (n_reg == CNT_W'(1)) && !pend_reg && (rdata_reg == CHAR_DOT);
        sts.out_free   = out_free;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_has_byte    = has_byte_reg;
    assign m_end_of_line = eol_reg;

endmodule

[hw/rtl/mail_line_folder.sv]
// Top level of the mail line folder: controller plus datapath.
// Depends on mlf_pkg, mlf_ctrl and mlf_datapath.
//
// Folds message text, one byte word in, into lines of at most line_length
// characters (clamped to 2..LINE_CAPACITY), one byte word out per line
// character; an empty line is one word with has_byte low. Each accepted byte
// starts a serial scan of the window memory, one entry per cycle, and every
// line cut then replays its bytes from that memory one at a time, since each
// read of the single read port is registered before it reaches the output
// register, which may stall the replay. No new byte is accepted until the
// scan and its line cuts are done; line_length is taken only while the window is empty.
module mail_line_folder
    import mlf_pkg::*;
#(
    parameter int LINE_CAPACITY = 60
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_last_byte,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_has_byte,
    output logic             m_end_of_line
);

    cmd_t cmd;
    sts_t sts;

    mlf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mlf_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_in_byte     (s_in_byte),
        .s_last_byte   (s_last_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_byte    (m_out_byte),
        .m_has_byte    (m_has_byte),
        .m_end_of_line (m_end_of_line)
    );

endmodule
